[rtl/nearest_point_match_top_defines.svh]
// Assertion macros shared by the nearest point matcher RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef NEAREST_POINT_MATCH_TOP_DEFINES_SVH
`define NEAREST_POINT_MATCH_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define NPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define NPM_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

[rtl/npm_pkg.sv]
// Package for the nearest point matcher: widths, codes, command and state types.
// Used by every module of the block; depends on nothing.
package npm_pkg;

   localparam int DEFAULT_CAPACITY = 1024;
   localparam int QUEUE_DEPTH      = 4;
   localparam int OP_W             = 2;
   localparam int COORD_W          = 16;
   localparam int INDEX_W          = 10;
   localparam int SQ_W             = 2 * COORD_W;
   localparam int DIST_W           = SQ_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_DONE
   } back_state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[rtl/nearest_point_match_top.sv]
// Nearest point matcher: an append request stores a point, a clear request empties the store,
// and a query request returns the index of the closest stored point by squared Euclidean
// distance, lowest index on ties. Appends and clears finish as the back end pops them; a
// query holds the back end while it pops the query, reads each of the N stored points through
// the single RAM read port, drains the distance pipeline and loads the response register,
// skipping the reads and the drain when the store is empty. A request passes the front
// register and the command queue before it reaches the back end. A four-entry command queue
// lets requests keep arriving while a scan runs, and a response register lets the next
// commands proceed while a result waits. No clearing pass is needed after reset: only entries
// below the point count are read. Uses npm_pkg, npm_front, npm_queue, npm_back and npm_ram.
module nearest_point_match_top
   import npm_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_match_index,
   output logic               rsp_store_empty,
   output logic               rsp_store_overflowed
);

   localparam int AW = addr_width(CAPACITY);

   logic            push;
   cmd_type         push_cmd;
   logic            queue_full;
   logic            queue_empty;
   logic            pop;
   cmd_type         head_cmd;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [SQ_W-1:0] ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   logic [SQ_W-1:0] ram_rd_data;

   npm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   npm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   npm_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_empty          (queue_empty),
      .head_cmd             (head_cmd),
      .pop                  (pop),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data),
      .ram_rd_en            (ram_rd_en),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_match_index      (rsp_match_index),
      .rsp_store_empty      (rsp_store_empty),
      .rsp_store_overflowed (rsp_store_overflowed)
   );

   npm_ram #(
      .WIDTH (SQ_W),
      .DEPTH (CAPACITY)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[rtl/npm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the reference points; uses the npm package for address sizing.
module npm_ram
   import npm_pkg::*;
#(
   parameter int WIDTH = 2 * COORD_W,
   parameter int DEPTH = DEFAULT_CAPACITY
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [addr_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   input  logic [addr_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/npm_queue.sv]
// Short command queue between the request front end and the execution back end.
// Uses the command type from the npm package.
`include "nearest_point_match_top_defines.svh"

module npm_queue
   import npm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `NPM_ASSERT(a_queue_no_push_full, push |-> !full, "queue pushed while full")
   `NPM_ASSERT(a_queue_no_pop_empty, pop |-> !empty, "queue popped while empty")
   `NPM_ASSERT(a_queue_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count above depth")

endmodule

[rtl/npm_front.sv]
// Front end: takes requests, drops unused operation codes and hands commands to the queue.
// Uses the op and command types from the npm package.
module npm_front
   import npm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   output logic               push,
   output cmd_type            push_cmd,
   input  logic               queue_full
);

   logic    front_valid_ff, front_valid_in;
   cmd_type front_cmd_ff, front_cmd_in;
   logic    accept;
   logic    is_cmd;

   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !queue_full;
   assign push_cmd  = front_cmd_ff;

   always_comb begin
      case (op_type'(req_op))
         OP_APPEND, OP_QUERY, OP_CLEAR: begin
            is_cmd = 1'b1;
         end
         default: begin
            is_cmd = 1'b0;
         end
      endcase
      front_cmd_in.op = op_type'(req_op);
      front_cmd_in.x  = req_point_x;
      front_cmd_in.y  = req_point_y;
      if (accept) begin
         front_valid_in = is_cmd;
      end else begin
         front_valid_in = front_valid_ff && !push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= front_cmd_in;
      end
   end

endmodule

[rtl/npm_back.sv]
// Back end: appends and clears the point store and scans it for queries.
// Drives the point RAM and the response register; uses the npm package types.
`include "nearest_point_match_top_defines.svh"

module npm_back
   import npm_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            queue_empty,
   input  cmd_type                         head_cmd,
   output logic                            pop,
   output logic                            ram_wr_en,
   output logic [addr_width(CAPACITY)-1:0] ram_wr_addr,
   output logic [SQ_W-1:0]                 ram_wr_data,
   output logic                            ram_rd_en,
   output logic [addr_width(CAPACITY)-1:0] ram_rd_addr,
   input  logic [SQ_W-1:0]                 ram_rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [INDEX_W-1:0]              rsp_match_index,
   output logic                            rsp_store_empty,
   output logic                            rsp_store_overflowed
);

   localparam int AW = addr_width(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      scan_idx_ff, scan_idx_in;
   logic [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;

   // Scan pipeline: RAM read, absolute differences, squares, compare.
   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [AW-1:0]      p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [DIST_W-1:0]  cand_d;
   logic               take;

   logic               have_best_ff, have_best_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_d_ff, best_d_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_empty_ff, rsp_ovf_ff;
   logic               rsp_load;
   logic               rsp_free;
   logic               issue;

   logic               pipe_busy;
   logic               quiet_state;
   logic               rsp_done;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      px    = ram_rd_data[SQ_W-1:COORD_W];
      py    = ram_rd_data[COORD_W-1:0];
      dx_in = (qx_ff >= px) ? qx_ff - px : px - qx_ff;
      dy_in = (qy_ff >= py) ? qy_ff - py : py - qy_ff;
   end

   assign cand_d = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   // Strict less-than keeps the lowest index on equal distances.
   assign take = p3_valid_ff && (!have_best_ff || (cand_d < best_d_ff));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      scan_idx_in  = scan_idx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      have_best_in = have_best_ff || take;
      best_idx_in  = take ? p3_idx_ff : best_idx_ff;
      best_d_in    = take ? cand_d : best_d_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(cnt_ff);
      ram_wr_data  = {head_cmd.x, head_cmd.y};
      issue        = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (head_cmd.op)
                  OP_APPEND: begin
                     if (cnt_ff < CW'(CAPACITY)) begin
                        ram_wr_en = 1'b1;
                        cnt_in    = cnt_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end
                  OP_QUERY: begin
                     qx_in        = head_cmd.x;
                     qy_in        = head_cmd.y;
                     scan_idx_in  = '0;
                     have_best_in = 1'b0;
                     best_idx_in  = '0;
                     state_in     = (cnt_ff == '0) ? BK_DONE : BK_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
            issue = 1'b1;
            if ((CW'(scan_idx_ff) + CW'(1)) == cnt_ff) begin
               state_in = BK_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         BK_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff && !p3_valid_ff) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign ram_rd_en   = issue;
   assign ram_rd_addr = scan_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      p1_idx_ff   <= scan_idx_ff;
      p2_idx_ff   <= p1_idx_ff;
      p3_idx_ff   <= p2_idx_ff;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqx_ff      <= dx_ff * dx_ff;
      sqy_ff      <= dy_ff * dy_ff;
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      if (rsp_load) begin
         rsp_index_ff <= INDEX_W'(32'(best_idx_ff));
         rsp_empty_ff <= (cnt_ff == '0);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_index      = rsp_index_ff;
   assign rsp_store_empty      = rsp_empty_ff;
   assign rsp_store_overflowed = rsp_ovf_ff;

   assign pipe_busy   = p1_valid_ff || p2_valid_ff || p3_valid_ff;
   assign quiet_state = (state_ff == BK_IDLE) || (state_ff == BK_DONE);
   assign rsp_done    = (state_ff == BK_DONE) && rsp_free;

   `NPM_ASSERT(a_count_bound, cnt_ff <= CW'(CAPACITY), "point count above capacity")
   `NPM_ASSERT(a_scan_in_range, (state_ff == BK_SCAN) |-> (CW'(scan_idx_ff) < cnt_ff), "scan past count")
   `NPM_ASSERT(a_pipe_quiet, quiet_state |-> !pipe_busy, "scan pipeline busy outside a scan")
   `NPM_ASSERT_NEXT(a_result_loaded, rsp_done, rsp_valid_ff && (state_ff == BK_IDLE), "result lost")

endmodule
